// ----- rtl/bivl_pkg.sv -----
`default_nettype none

package bivl_pkg;

    localparam int FIELD_W = 24;
    localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

    localparam logic [2:0] PH_SEARCH  = 3'd0;
    localparam logic [2:0] PH_VALUE   = 3'd1;
    localparam logic [2:0] PH_INT     = 3'd2;
    localparam logic [2:0] PH_STRLEN  = 3'd3;
    localparam logic [2:0] PH_STRBODY = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ABSENT  = 3'd1;
    localparam logic [2:0] ST_TRUNC   = 3'd2;
    localparam logic [2:0] ST_BADSTR  = 3'd3;
    localparam logic [2:0] ST_BADCHAR = 3'd4;
    localparam logic [2:0] ST_DEEP    = 3'd5;

    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_FOUR  = 8'h34;

    localparam logic [2:0] KEY_LEN = 3'd6;

    typedef struct packed {
        logic [FIELD_W-1:0] value_length;
        logic [FIELD_W-1:0] value_offset;
        logic [2:0]         status;
    } result_t;

    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h34;
            3'd1: ch = 8'h3A;
            3'd2: ch = 8'h69;
            3'd3: ch = 8'h6E;
            3'd4: ch = 8'h66;
            3'd5: ch = 8'h6F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bivl_step.sv -----
`default_nettype none

module bivl_step #(
    parameter int POSITION_BITS = 24,
    parameter int MAX_DEPTH     = 64
) (
    input  wire logic [7:0]                       data_byte,
    input  wire logic                             last,
    input  wire logic [2:0]                       phase,
    input  wire logic [2:0]                       key_cnt,
    input  wire logic [POSITION_BITS-1:0]         pos,
    input  wire logic [POSITION_BITS-1:0]         vstart,
    input  wire logic [$clog2(MAX_DEPTH+1)-1:0]   depth,
    input  wire logic [POSITION_BITS-1:0]         remain,
    output logic [2:0]                            phase_n,
    output logic [2:0]                            key_cnt_n,
    output logic [POSITION_BITS-1:0]              pos_n,
    output logic [POSITION_BITS-1:0]              vstart_n,
    output logic [$clog2(MAX_DEPTH+1)-1:0]        depth_n,
    output logic [POSITION_BITS-1:0]              remain_n,
    output logic                                  emit,
    output bivl_pkg::result_t                     result
);

    localparam int P  = POSITION_BITS;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int CW = (P > bivl_pkg::FIELD_W) ? P : bivl_pkg::FIELD_W;
    localparam logic [P-1:0] POS_MAX = {P{1'b1}};

    logic            is_digit;
    logic [3:0]      digit;
    logic [P-1:0]    pos_inc;
    logic [2:0]      key_step;
    logic            key_done;
    logic [P-1:0]    vs_upd;
    logic [P-1:0]    span;
    logic [P+3:0]    len_wide;
    logic [P-1:0]    rem_dec;
    logic [2:0]      st;
    logic [P-1:0]    len;
    logic [CW-1:0]   vs_ext;
    logic [CW-1:0]   len_ext;

    assign is_digit = (data_byte >= bivl_pkg::CH_ZERO) && (data_byte <= bivl_pkg::CH_NINE);
    assign digit    = data_byte[3:0];
    assign pos_inc  = (pos == POS_MAX) ? pos : pos + 1'b1;

    assign key_step = ((key_cnt < bivl_pkg::KEY_LEN) && (data_byte == bivl_pkg::key_char(key_cnt)))
                    ? key_cnt + 3'd1
                    : ((data_byte == bivl_pkg::CH_FOUR) ? 3'd1 : 3'd0);
    assign key_done = (phase == bivl_pkg::PH_SEARCH) && (key_step >= bivl_pkg::KEY_LEN);
    assign vs_upd   = key_done ? pos_inc : vstart;
    assign span     = (pos_inc >= vs_upd) ? pos_inc - vs_upd : '0;

    assign len_wide = {remain, 3'b000} + {3'b000, remain, 1'b0} + {{P{1'b0}}, digit};
    assign rem_dec  = (remain != '0) ? remain - 1'b1 : remain;

    always_comb begin
        phase_n   = phase;
        key_cnt_n = key_cnt;
        depth_n   = depth;
        remain_n  = remain;
        vstart_n  = vs_upd;
        pos_n     = pos_inc;
        emit      = 1'b0;
        st        = bivl_pkg::ST_OK;
        len       = '0;
        case (phase)
            bivl_pkg::PH_SEARCH: begin
                key_cnt_n = key_step;
                if (key_done) begin
                    depth_n = '0;
                    phase_n = bivl_pkg::PH_VALUE;
                    if (last) begin
                        emit    = 1'b1;
                        st      = bivl_pkg::ST_TRUNC;
                        phase_n = bivl_pkg::PH_DONE;
                    end
                end
            end
            bivl_pkg::PH_VALUE: begin
                if (data_byte == bivl_pkg::CH_I) begin
                    phase_n = bivl_pkg::PH_INT;
                end else if (data_byte == bivl_pkg::CH_L || data_byte == bivl_pkg::CH_D) begin
                    if (depth >= DW'(MAX_DEPTH)) begin
                        emit    = 1'b1;
                        st      = bivl_pkg::ST_DEEP;
                        phase_n = bivl_pkg::PH_DONE;
                    end else begin
                        depth_n = depth + 1'b1;
                    end
                end else if (data_byte == bivl_pkg::CH_E) begin
                    if (depth <= DW'(1)) begin
                        depth_n = '0;
                        emit    = 1'b1;
                        len     = span;
                        phase_n = bivl_pkg::PH_DONE;
                    end else begin
                        depth_n = depth - 1'b1;
                    end
                end else if (is_digit) begin
                    remain_n = P'(digit);
                    phase_n  = bivl_pkg::PH_STRLEN;
                end else begin
                    emit    = 1'b1;
                    st      = bivl_pkg::ST_BADCHAR;
                    phase_n = bivl_pkg::PH_DONE;
                end
            end
            bivl_pkg::PH_INT: begin
                if (data_byte == bivl_pkg::CH_E) begin
                    if (depth == '0) begin
                        emit    = 1'b1;
                        len     = span;
                        phase_n = bivl_pkg::PH_DONE;
                    end else begin
                        phase_n = bivl_pkg::PH_VALUE;
                    end
                end
            end
            bivl_pkg::PH_STRLEN: begin
                if (is_digit) begin
                    remain_n = (len_wide > (P+4)'(POS_MAX)) ? POS_MAX : len_wide[P-1:0];
                end else if (data_byte == bivl_pkg::CH_COLON) begin
                    if (remain != '0) begin
                        phase_n = bivl_pkg::PH_STRBODY;
                    end else if (depth == '0) begin
                        emit    = 1'b1;
                        len     = span;
                        phase_n = bivl_pkg::PH_DONE;
                    end else begin
                        phase_n = bivl_pkg::PH_VALUE;
                    end
                end else begin
                    emit    = 1'b1;
                    st      = bivl_pkg::ST_BADSTR;
                    phase_n = bivl_pkg::PH_DONE;
                end
            end
            bivl_pkg::PH_STRBODY: begin
                remain_n = rem_dec;
                if (rem_dec == '0) begin
                    if (depth == '0) begin
                        emit    = 1'b1;
                        len     = span;
                        phase_n = bivl_pkg::PH_DONE;
                    end else begin
                        phase_n = bivl_pkg::PH_VALUE;
                    end
                end
            end
            default: begin
            end
        endcase

        if (last) begin
            if (!emit) begin
                if (phase_n == bivl_pkg::PH_SEARCH) begin
                    emit = 1'b1;
                    st   = bivl_pkg::ST_ABSENT;
                end else if (phase_n == bivl_pkg::PH_STRLEN) begin
                    emit = 1'b1;
                    st   = bivl_pkg::ST_BADSTR;
                end else if (phase_n != bivl_pkg::PH_DONE) begin
                    emit = 1'b1;
                    st   = bivl_pkg::ST_OK;
                    len  = span;
                end
            end
            phase_n   = bivl_pkg::PH_SEARCH;
            key_cnt_n = '0;
            pos_n     = '0;
            vstart_n  = '0;
            depth_n   = '0;
            remain_n  = '0;
        end
    end

    assign vs_ext  = CW'(vs_upd);
    assign len_ext = CW'(len);

    always_comb begin
        result.status = st;
        if (st == bivl_pkg::ST_ABSENT) begin
            result.value_offset = '0;
        end else if (vs_ext > CW'(bivl_pkg::FIELD_MAX)) begin
            result.value_offset = bivl_pkg::FIELD_MAX;
        end else begin
            result.value_offset = vs_ext[bivl_pkg::FIELD_W-1:0];
        end
        if (st != bivl_pkg::ST_OK) begin
            result.value_length = '0;
        end else if (len_ext > CW'(bivl_pkg::FIELD_MAX)) begin
            result.value_length = bivl_pkg::FIELD_MAX;
        end else begin
            result.value_length = len_ext[bivl_pkg::FIELD_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bencode_info_value_locator.sv -----
// Channel   Direction  tdata (low bit up)                          tuser / tlast
// s_axis    in         data_byte[7:0]                              tlast = end_of_buffer
// m_axis    out        status[2:0], value_offset, value_length     tlast unused
//
// Each byte is handled combinationally in the step logic; a new byte is taken every
// cycle while the result register is not stalled. A byte passes through the input register, then the result register.
// The result register holds one result; while it is stalled the input register
// still takes one byte, and further bytes wait.
// aresetn is synchronous and returns the scanner to key search at offset zero.
`default_nettype none

module bencode_info_value_locator #(
    parameter int POSITION_BITS = 24,
    parameter int MAX_DEPTH     = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tlast,   // end_of_buffer
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata    // status, value_offset, value_length, zero pad
);

    localparam int P  = POSITION_BITS;
    localparam int DW = $clog2(MAX_DEPTH + 1);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic [2:0]          phase_reg, phase_next;
    logic [2:0]          key_cnt_reg, key_cnt_next;
    logic [P-1:0]        pos_reg, pos_next;
    logic [P-1:0]        vstart_reg, vstart_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [P-1:0]        remain_reg, remain_next;
    logic                out_valid_reg;
    bivl_pkg::result_t   out_result_reg;
    logic                emit;
    bivl_pkg::result_t   step_result;
    logic                advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_result_reg};

    bivl_step #(
        .POSITION_BITS (POSITION_BITS),
        .MAX_DEPTH     (MAX_DEPTH)
    ) u_step (
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .phase     (phase_reg),
        .key_cnt   (key_cnt_reg),
        .pos       (pos_reg),
        .vstart    (vstart_reg),
        .depth     (depth_reg),
        .remain    (remain_reg),
        .phase_n   (phase_next),
        .key_cnt_n (key_cnt_next),
        .pos_n     (pos_next),
        .vstart_n  (vstart_next),
        .depth_n   (depth_next),
        .remain_n  (remain_next),
        .emit      (emit),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= bivl_pkg::PH_SEARCH;
            key_cnt_reg   <= '0;
            pos_reg       <= '0;
            vstart_reg    <= '0;
            depth_reg     <= '0;
            remain_reg    <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_axis_tdata;
                in_last_reg  <= s_axis_tlast;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && emit) begin
                out_valid_reg  <= 1'b1;
                out_result_reg <= step_result;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                phase_reg   <= phase_next;
                key_cnt_reg <= key_cnt_next;
                pos_reg     <= pos_next;
                vstart_reg  <= vstart_next;
                depth_reg   <= depth_next;
                remain_reg  <= remain_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_len_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_result_reg.status != bivl_pkg::ST_OK)
        |-> (out_result_reg.value_length == '0))
        else $error("nonzero length on an error result");

    a_absent_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_result_reg.status == bivl_pkg::ST_ABSENT)
        |-> (out_result_reg.value_offset == '0))
        else $error("nonzero offset on a key-absent result");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(MAX_DEPTH))
        else $error("nesting depth beyond its bound");

    a_buffer_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg
        |=> (phase_reg == bivl_pkg::PH_SEARCH) && (pos_reg == '0) && (key_cnt_reg == '0))
        else $error("scanner not restarted after the final byte of a buffer");
`endif

endmodule

`default_nettype wire
